FILE: rtl/fbfl_pkg.sv
// Shared constants, codes and controller/datapath interface types for the chunk allocator.
package fbfl_pkg;

	localparam int MAX_CHUNKS = 256;
	localparam int IDX_W      = $clog2(MAX_CHUNKS);
	localparam int LINK_W     = IDX_W + 1;
	localparam int CNT_W      = 9;
	localparam int CMP_W      = (LINK_W > CNT_W) ? LINK_W : CNT_W;
	localparam int CMD_W      = 2;
	localparam int CIDX_W     = 8;
	localparam int GRANT_W    = 8;
	localparam int STAT_W     = 2;
	localparam int IN_W       = 16;
	localparam int OUT_W      = 16;

	localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FREE_ALL = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ALLOC_WB,
		S_SWEEP
	} state_t;

	typedef struct packed {
		logic                link_rd;
		logic                head_from_link;
		logic                push;
		logic                sweep_clr;
		logic                sweep_wr;
		logic                head_clr;
		logic                res_load;
		logic                res_grant;
		logic [STAT_W-1:0]   res_status;
	} ctl_cmd_t;

	typedef struct packed {
		logic head_ok;
		logic idx_ok;
		logic count_zero;
		logic sweep_last;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/fixed_block_free_list_allocator.sv
// Top level of the fixed-size chunk free-list allocator.
//
// Input stream s_*: one command per item. s_tdata carries cmd in [1:0]
// (0 allocate, 1 free, 2 free all) and chunk_index in [9:2].
// Output stream m_*: exactly one result per command, in order. m_tdata
// carries granted_index in [7:0] and status in [9:8] (0 ok, 1 empty,
// 2 free index out of range).
// cfg_we/cfg_wdata write chunk_count; write it only while the block is idle.
// Free, a failed allocate, an unused command and free-all on an empty
// pool load the result register when accepted; a successful allocate
// first reads the link store, then updates the head and loads the result;
// free-all sweeps chunk_count entries, with the count saturated at 256,
// of the link store one entry per cycle through its single write port.
// One item is handled at a time; the next is accepted once the controller
// is idle and the result register is free or draining.
// A stalled receiver holds the result register and stops new accepts.
// Reset: chunk_count is 256, the head is chunk 0 and every link reads as
// its index plus one through per-entry valid bits; no clearing pass.
module fixed_block_free_list_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [fbfl_pkg::IN_W-1:0]   s_tdata,   // cmd[1:0], chunk_index[9:2]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [fbfl_pkg::OUT_W-1:0]  m_tdata,   // granted_index[7:0], status[9:8]
	input  logic                        cfg_we,
	input  logic [fbfl_pkg::CNT_W-1:0]  cfg_wdata  // chunk_count
);
	import fbfl_pkg::*;

	ctl_cmd_t          ctl;
	dp_stat_t          stat;
	logic [CMD_W-1:0]  cmd;
	logic [CIDX_W-1:0] chunk_index;

	assign cmd         = s_tdata[CMD_W-1:0];
	assign chunk_index = s_tdata[CMD_W+CIDX_W-1:CMD_W];

	fbfl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.cmd     (cmd),
		.stat    (stat),
		.ctl     (ctl)
	);

	fbfl_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.chunk_index(chunk_index),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

FILE: rtl/fbfl_ram.sv
// Generic single-port-write, registered-read RAM.
module fbfl_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/fbfl_dp.sv
// Datapath: link store, head and count registers, sweep pointer and result register.
module fbfl_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fbfl_pkg::ctl_cmd_t           ctl,
	output fbfl_pkg::dp_stat_t           stat,
	input  logic [fbfl_pkg::CIDX_W-1:0]  chunk_index,
	input  logic                         cfg_we,
	input  logic [fbfl_pkg::CNT_W-1:0]   cfg_wdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [fbfl_pkg::OUT_W-1:0]   m_tdata
);
	import fbfl_pkg::*;

	logic [CNT_W-1:0]      count_q;
	logic [LINK_W-1:0]     head_q;
	logic [IDX_W-1:0]      ptr_q;
	logic [MAX_CHUNKS-1:0] vld_q;
	logic                  vld_s1;
	logic                  out_vld_q;
	logic [GRANT_W-1:0]    grant_q;
	logic [STAT_W-1:0]     status_q;

	logic [CMP_W-1:0]  live;
	logic [CMP_W-1:0]  idx_ext;
	logic [IDX_W-1:0]  head_idx;
	logic [IDX_W-1:0]  free_idx;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [LINK_W-1:0] wdata;
	logic [LINK_W-1:0] rdata;
	logic [LINK_W-1:0] link;

	// Saturate the pool size to the store depth.
	assign live     = (CMP_W'(count_q) > CMP_W'(MAX_CHUNKS)) ? CMP_W'(MAX_CHUNKS)
	                                                          : CMP_W'(count_q);
	assign idx_ext  = CMP_W'(chunk_index);
	assign head_idx = head_q[IDX_W-1:0];
	assign free_idx = IDX_W'(chunk_index);

	assign stat.head_ok    = CMP_W'(head_q) < live;
	assign stat.idx_ok     = idx_ext < live;
	assign stat.count_zero = live == '0;
	assign stat.sweep_last = (CMP_W'(ptr_q) + CMP_W'(1)) == live;
	assign stat.out_free   = !out_vld_q || m_tready;

	// One write port shared by push and the free-all sweep.
	assign we    = ctl.push || ctl.sweep_wr;
	assign waddr = ctl.sweep_wr ? ptr_q : free_idx;
	assign wdata = ctl.sweep_wr ? (LINK_W'(ptr_q) + LINK_W'(1)) : head_q;

	fbfl_ram #(
		.WIDTH(LINK_W),
		.DEPTH(MAX_CHUNKS)
	) u_link_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(head_idx),
		.rdata(rdata)
	);

	// An entry never written holds its reset link, index plus one.
	assign link = vld_s1 ? rdata : (head_q + LINK_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(256);
			head_q  <= '0;
			vld_q   <= '0;
			ptr_q   <= '0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (ctl.sweep_clr) begin
				ptr_q <= '0;
			end else if (ctl.sweep_wr) begin
				ptr_q <= ptr_q + IDX_W'(1);
			end
			if (ctl.head_clr) begin
				head_q <= '0;
			end else if (ctl.push) begin
				head_q <= LINK_W'(chunk_index);
			end else if (ctl.head_from_link) begin
				head_q <= link;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.link_rd) begin
			vld_s1 <= vld_q[head_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.res_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			grant_q  <= ctl.res_grant ? GRANT_W'(head_q) : '0;
			status_q <= ctl.res_status;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_W'({status_q, grant_q});

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.res_load |-> (!out_vld_q || m_tready))
		else $error("result register overwritten while pending");

	a_push_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> (idx_ext < live))
		else $error("push of out-of-range chunk");

	a_sweep_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.sweep_wr |-> (CMP_W'(ptr_q) < live))
		else $error("sweep pointer past pool end");

	a_link_read_first: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.head_from_link |-> $past(ctl.link_rd))
		else $error("head updated without a link read");

endmodule

FILE: rtl/fbfl_ctrl.sv
// Controller: command decode and sequencing state machine.
module fbfl_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [fbfl_pkg::CMD_W-1:0]  cmd,
	input  fbfl_pkg::dp_stat_t          stat,
	output fbfl_pkg::ctl_cmd_t          ctl
);
	import fbfl_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign s_tready = (state_q == S_IDLE) && stat.out_free;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					ctl.res_status = ST_OK;
					unique case (cmd)
						CMD_ALLOC: begin
							if (stat.head_ok) begin
								ctl.link_rd = 1'b1;
								state_d     = S_ALLOC_WB;
							end else begin
								ctl.res_load   = 1'b1;
								ctl.res_status = ST_EMPTY;
							end
						end
						CMD_FREE: begin
							ctl.res_load = 1'b1;
							if (stat.idx_ok) begin
								ctl.push = 1'b1;
							end else begin
								ctl.res_status = ST_RANGE;
							end
						end
						CMD_FREE_ALL: begin
							if (stat.count_zero) begin
								ctl.head_clr = 1'b1;
								ctl.res_load = 1'b1;
							end else begin
								ctl.sweep_clr = 1'b1;
								state_d       = S_SWEEP;
							end
						end
						default: begin
							// unused command: no state change, plain ok
							ctl.res_load = 1'b1;
						end
					endcase
				end
			end
			S_ALLOC_WB: begin
				ctl.head_from_link = 1'b1;
				ctl.res_load       = 1'b1;
				ctl.res_grant      = 1'b1;
				ctl.res_status     = ST_OK;
				state_d            = S_IDLE;
			end
			S_SWEEP: begin
				ctl.sweep_wr = 1'b1;
				if (stat.sweep_last) begin
					ctl.head_clr   = 1'b1;
					ctl.res_load   = 1'b1;
					ctl.res_status = ST_OK;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_ready_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == S_IDLE))
		else $error("input ready outside idle");

	a_alloc_wb_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC_WB) |=> (state_q == S_IDLE))
		else $error("allocate write-back did not return to idle");

	a_sweep_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_SWEEP) |-> $past(accept))
		else $error("sweep entered without an accepted item");

endmodule
